>>> rtl/lod_stitched_grid_index_generator_unit_macros.svh
// Assertion macros shared by the generator RTL.
`ifndef LOD_STITCHED_GRID_INDEX_GENERATOR_UNIT_MACROS_SVH
`define LOD_STITCHED_GRID_INDEX_GENERATOR_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LSGI_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lsgi: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define LSGI_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lsgi: next-cycle check failed");

`endif

>>> rtl/lsgi_pkg.sv
package lsgi_pkg;

  localparam int unsigned IDX_W          = 15;
  localparam int unsigned CFG_W          = 3;
  localparam int unsigned LOD_W          = 2;
  localparam int unsigned MASK_W         = 4;
  localparam int unsigned LOG_W          = 4;
  localparam int unsigned MIN_PATCH_LOG2 = 2;
  localparam logic [CFG_W-1:0] CFG_RESET = 3'd5;

  localparam int unsigned STITCH_NORTH_BIT = 0;
  localparam int unsigned STITCH_SOUTH_BIT = 1;
  localparam int unsigned STITCH_WEST_BIT  = 2;
  localparam int unsigned STITCH_EAST_BIT  = 3;

  // Bit k+1 of a fan section code lines up with stitch mask bit k.
  typedef enum logic [4:0] {
    SEC_MAIN  = 5'b00001,
    SEC_NORTH = 5'b00010,
    SEC_SOUTH = 5'b00100,
    SEC_WEST  = 5'b01000,
    SEC_EAST  = 5'b10000
  } section_e;

  typedef enum logic [1:0] {
    TRI_0 = 2'd0,
    TRI_1 = 2'd1,
    TRI_2 = 2'd2
  } sub_e;

  typedef struct packed {
    section_e sec;
    sub_e     sub;
  } cursor_ctl_t;

endpackage

>>> rtl/lsgi_tri_corners.sv
module lsgi_tri_corners #(
  parameter int unsigned MAX_PATCH_LOG2 = 7
) (
  input  lsgi_pkg::cursor_ctl_t              ctl_i,
  input  logic [MAX_PATCH_LOG2-1:0]          row_i,
  input  logic [MAX_PATCH_LOG2-1:0]          col_i,
  input  logic [MAX_PATCH_LOG2:0]            step_i,
  input  logic [lsgi_pkg::LOG_W-1:0]         log2_i,
  output logic [lsgi_pkg::IDX_W-1:0]         corner_a_o,
  output logic [lsgi_pkg::IDX_W-1:0]         corner_b_o,
  output logic [lsgi_pkg::IDX_W-1:0]         corner_c_o
);

  localparam int unsigned CW = MAX_PATCH_LOG2 + 1;
  localparam int unsigned WW = CW + MAX_PATCH_LOG2 + 1;

  logic [CW-1:0] s, s2, p, z, x;
  logic [CW-1:0] za, xa, zb, xb, zc, xc;

  function automatic logic [lsgi_pkg::IDX_W-1:0] vtx(
    input logic [CW-1:0]              zz,
    input logic [CW-1:0]              xx,
    input logic [lsgi_pkg::LOG_W-1:0] sh
  );
    logic [WW-1:0] acc;
    acc = (WW'(zz) << sh) + WW'(zz) + WW'(xx);
    return lsgi_pkg::IDX_W'(acc);
  endfunction

  always_comb begin
    s  = step_i;
    s2 = step_i << 1;
    p  = CW'(1) << log2_i;
    z  = CW'(row_i);
    x  = CW'(col_i);
    za = '0; xa = '0; zb = '0; xb = '0; zc = '0; xc = '0;
    case (ctl_i.sec)
      lsgi_pkg::SEC_NORTH: begin
        z = p - s;
        case (ctl_i.sub)
          lsgi_pkg::TRI_0: begin
            za = z + s; xa = x;     zb = z;     xb = x + s;  zc = z; xc = x;
          end
          lsgi_pkg::TRI_1: begin
            za = z + s; xa = x;     zb = z + s; xb = x + s2; zc = z; xc = x + s;
          end
          default: begin
            za = z + s; xa = x + s2; zb = z;    xb = x + s2; zc = z; xc = x + s;
          end
        endcase
      end
      lsgi_pkg::SEC_SOUTH: begin
        case (ctl_i.sub)
          lsgi_pkg::TRI_0: begin
            za = s;  xa = x;     zb = s; xb = x + s;  zc = '0; xc = x;
          end
          lsgi_pkg::TRI_1: begin
            za = '0; xa = x;     zb = s; xb = x + s;  zc = '0; xc = x + s2;
          end
          default: begin
            za = s;  xa = x + s; zb = s; xb = x + s2; zc = '0; xc = x + s2;
          end
        endcase
      end
      lsgi_pkg::SEC_WEST: begin
        case (ctl_i.sub)
          lsgi_pkg::TRI_0: begin
            za = z;      xa = '0; zb = z + s;  xb = s; zc = z;     xc = s;
          end
          lsgi_pkg::TRI_1: begin
            za = z + s2; xa = '0; zb = z + s;  xb = s; zc = z;     xc = '0;
          end
          default: begin
            za = z + s2; xa = '0; zb = z + s2; xb = s; zc = z + s; xc = s;
          end
        endcase
      end
      lsgi_pkg::SEC_EAST: begin
        x = p - s;
        case (ctl_i.sub)
          lsgi_pkg::TRI_0: begin
            za = z;     xa = x; zb = z + s;  xb = x;     zc = z;      xc = x + s;
          end
          lsgi_pkg::TRI_1: begin
            za = z + s; xa = x; zb = z + s2; xb = x + s; zc = z;      xc = x + s;
          end
          default: begin
            za = z + s; xa = x; zb = z + s2; xb = x;     zc = z + s2; xc = x + s;
          end
        endcase
      end
      default: begin
        if (ctl_i.sub == lsgi_pkg::TRI_0) begin
          za = z + s; xa = x; zb = z;     xb = x + s; zc = z; xc = x;
        end else begin
          za = z + s; xa = x; zb = z + s; xb = x + s; zc = z; xc = x + s;
        end
      end
    endcase
  end

  assign corner_a_o = vtx(za, xa, log2_i);
  assign corner_b_o = vtx(zb, xb, log2_i);
  assign corner_c_o = vtx(zc, xc, log2_i);

endmodule

>>> rtl/lod_stitched_grid_index_generator_unit.sv
// Generates the triangle list of a square terrain patch at a chosen detail level, one triangle
// per transfer: the main grid by rows, then the north, south, west and east stitching fans.
// A transfer with restart set latches the level and stitch mask and yields the first triangle of
// the new range at once; while a range runs, every input transfer yields exactly one triangle and
// the final one carries last_in_range. With no range running and restart clear, an input
// transfer yields nothing. The cursor update and the shift-add index datapath sit between the
// cursor registers and the result register, so a triangle can be taken every cycle, and input is
// held back only while the result register is full and not being taken. Writing patch_size_log2
// ends any range in progress.
`include "lod_stitched_grid_index_generator_unit_macros.svh"

module lod_stitched_grid_index_generator_unit #(
  parameter int unsigned MAX_PATCH_LOG2 = 7,
  parameter int unsigned MAX_LEVELS     = 4
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [lsgi_pkg::CFG_W-1:0]        cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              restart_i,
  input  logic [lsgi_pkg::LOD_W-1:0]        lod_level_i,
  input  logic [lsgi_pkg::MASK_W-1:0]       stitch_mask_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [lsgi_pkg::IDX_W-1:0]        corner_a_o,
  output logic [lsgi_pkg::IDX_W-1:0]        corner_b_o,
  output logic [lsgi_pkg::IDX_W-1:0]        corner_c_o,
  output logic                              last_in_range_o
);

  localparam int unsigned PW = MAX_PATCH_LOG2;
  localparam int unsigned CW = PW + 1;
  localparam int unsigned SW = CW + 1;

  logic [lsgi_pkg::CFG_W-1:0]  patch_log2_q;
  logic                        busy_q;
  logic [lsgi_pkg::LOD_W-1:0]  level_q;
  logic [lsgi_pkg::MASK_W-1:0] mask_q;
  lsgi_pkg::section_e          sec_q;
  lsgi_pkg::sub_e              sub_q;
  logic [PW-1:0]               row_q, col_q;
  logic                        out_valid_q;
  logic [lsgi_pkg::IDX_W-1:0]  corner_a_q, corner_b_q, corner_c_q;
  logic                        last_q;

  logic [lsgi_pkg::LOG_W-1:0]  log2_eff, coarsest;
  logic                        in_fire;

  logic                        cur_busy;
  logic [lsgi_pkg::LOD_W-1:0]  cur_level;
  logic [lsgi_pkg::MASK_W-1:0] cur_mask;
  lsgi_pkg::cursor_ctl_t       cur_ctl;
  logic [PW-1:0]               cur_row, cur_col;

  logic                        busy_d;
  lsgi_pkg::section_e          sec_d;
  lsgi_pkg::sub_e              sub_d;
  logic [PW-1:0]               row_d, col_d;

  logic [CW-1:0]               step;
  logic [SW-1:0]               s_w, p_w, x_start, z_start, x_end, z_end;
  logic [SW-1:0]               col_inc, row_inc, along, along2;
  logic                        fan_end, fan_ns, go_next;
  logic [lsgi_pkg::MASK_W-1:0] rem;
  logic [lsgi_pkg::IDX_W-1:0]  corner_a_d, corner_b_d, corner_c_d;
  logic                        in_main, in_fan;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    if (int'(patch_log2_q) < int'(lsgi_pkg::MIN_PATCH_LOG2)) begin
      log2_eff = lsgi_pkg::LOG_W'(lsgi_pkg::MIN_PATCH_LOG2);
    end else if (int'(patch_log2_q) > int'(MAX_PATCH_LOG2)) begin
      log2_eff = lsgi_pkg::LOG_W'(MAX_PATCH_LOG2);
    end else begin
      log2_eff = lsgi_pkg::LOG_W'(patch_log2_q);
    end
    if (int'(log2_eff) - int'(lsgi_pkg::MIN_PATCH_LOG2) > int'(MAX_LEVELS) - 1) begin
      coarsest = lsgi_pkg::LOG_W'(MAX_LEVELS - 1);
    end else begin
      coarsest = log2_eff - lsgi_pkg::LOG_W'(lsgi_pkg::MIN_PATCH_LOG2);
    end
  end

  // Cursor as seen by this transfer, after a restart has taken effect.
  always_comb begin
    cur_busy    = busy_q;
    cur_level   = level_q;
    cur_mask    = mask_q;
    cur_ctl.sec = sec_q;
    cur_ctl.sub = sub_q;
    if (restart_i) begin
      cur_busy    = 1'b1;
      cur_ctl.sec = lsgi_pkg::SEC_MAIN;
      cur_ctl.sub = lsgi_pkg::TRI_0;
      if (lsgi_pkg::LOG_W'(lod_level_i) >= coarsest) begin
        cur_level = lsgi_pkg::LOD_W'(coarsest);
        cur_mask  = '0;
      end else begin
        cur_level = lod_level_i;
        cur_mask  = stitch_mask_i;
      end
    end
    step    = CW'(1) << cur_level;
    s_w     = SW'(step);
    p_w     = SW'(1) << log2_eff;
    x_start = cur_mask[lsgi_pkg::STITCH_WEST_BIT]  ? s_w : '0;
    z_start = cur_mask[lsgi_pkg::STITCH_SOUTH_BIT] ? s_w : '0;
    x_end   = p_w - (cur_mask[lsgi_pkg::STITCH_EAST_BIT]  ? s_w : '0);
    z_end   = p_w - (cur_mask[lsgi_pkg::STITCH_NORTH_BIT] ? s_w : '0);
    cur_row = restart_i ? PW'(z_start) : row_q;
    cur_col = restart_i ? PW'(x_start) : col_q;
  end

  always_comb begin
    fan_ns  = (cur_ctl.sec == lsgi_pkg::SEC_NORTH) || (cur_ctl.sec == lsgi_pkg::SEC_SOUTH);
    col_inc = SW'(cur_col) + s_w;
    row_inc = SW'(cur_row) + s_w;
    along   = fan_ns ? SW'(cur_col) : SW'(cur_row);
    along2  = along + (s_w << 1);
    fan_end = along2 >= p_w;

    rem = cur_mask;
    case (cur_ctl.sec)
      lsgi_pkg::SEC_MAIN: begin
      end
      lsgi_pkg::SEC_NORTH: begin
        rem[lsgi_pkg::STITCH_NORTH_BIT] = 1'b0;
      end
      lsgi_pkg::SEC_SOUTH: begin
        rem[lsgi_pkg::STITCH_NORTH_BIT] = 1'b0;
        rem[lsgi_pkg::STITCH_SOUTH_BIT] = 1'b0;
      end
      lsgi_pkg::SEC_WEST: begin
        rem[lsgi_pkg::STITCH_NORTH_BIT] = 1'b0;
        rem[lsgi_pkg::STITCH_SOUTH_BIT] = 1'b0;
        rem[lsgi_pkg::STITCH_WEST_BIT]  = 1'b0;
      end
      default: begin
        rem = '0;
      end
    endcase

    go_next = 1'b0;
    busy_d  = cur_busy;
    sec_d   = cur_ctl.sec;
    sub_d   = cur_ctl.sub;
    row_d   = cur_row;
    col_d   = cur_col;

    if (cur_ctl.sec == lsgi_pkg::SEC_MAIN) begin
      if (cur_ctl.sub == lsgi_pkg::TRI_0) begin
        sub_d = lsgi_pkg::TRI_1;
      end else begin
        sub_d = lsgi_pkg::TRI_0;
        if (col_inc >= x_end) begin
          col_d = PW'(x_start);
          if (row_inc >= z_end) begin
            go_next = 1'b1;
          end else begin
            row_d = PW'(row_inc);
          end
        end else begin
          col_d = PW'(col_inc);
        end
      end
    end else begin
      case (cur_ctl.sub)
        lsgi_pkg::TRI_0: begin
          sub_d = lsgi_pkg::TRI_1;
        end
        lsgi_pkg::TRI_1: begin
          if (fan_end && (fan_ns ? cur_mask[lsgi_pkg::STITCH_EAST_BIT]
                                 : cur_mask[lsgi_pkg::STITCH_NORTH_BIT])) begin
            go_next = 1'b1;
          end else begin
            sub_d = lsgi_pkg::TRI_2;
          end
        end
        default: begin
          if (fan_end) begin
            go_next = 1'b1;
          end else begin
            sub_d = lsgi_pkg::TRI_0;
            if (fan_ns) begin
              col_d = PW'(along2);
            end else begin
              row_d = PW'(along2);
            end
          end
        end
      endcase
    end

    if (go_next) begin
      row_d = '0;
      col_d = '0;
      if (rem[lsgi_pkg::STITCH_NORTH_BIT]) begin
        sec_d = lsgi_pkg::SEC_NORTH;
      end else if (rem[lsgi_pkg::STITCH_SOUTH_BIT]) begin
        sec_d = lsgi_pkg::SEC_SOUTH;
      end else if (rem[lsgi_pkg::STITCH_WEST_BIT]) begin
        sec_d = lsgi_pkg::SEC_WEST;
      end else if (rem[lsgi_pkg::STITCH_EAST_BIT]) begin
        sec_d = lsgi_pkg::SEC_EAST;
      end else begin
        busy_d = 1'b0;
      end
      // A fan whose first corner is stitched starts on its middle triangle.
      if ((sec_d == lsgi_pkg::SEC_NORTH) || (sec_d == lsgi_pkg::SEC_SOUTH)) begin
        sub_d = cur_mask[lsgi_pkg::STITCH_WEST_BIT] ? lsgi_pkg::TRI_1 : lsgi_pkg::TRI_0;
      end else begin
        sub_d = cur_mask[lsgi_pkg::STITCH_SOUTH_BIT] ? lsgi_pkg::TRI_1 : lsgi_pkg::TRI_0;
      end
    end
  end

  lsgi_tri_corners #(
    .MAX_PATCH_LOG2(MAX_PATCH_LOG2)
  ) u_corners (
    .ctl_i     (cur_ctl),
    .row_i     (cur_row),
    .col_i     (cur_col),
    .step_i    (step),
    .log2_i    (log2_eff),
    .corner_a_o(corner_a_d),
    .corner_b_o(corner_b_d),
    .corner_c_o(corner_c_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      patch_log2_q <= lsgi_pkg::CFG_RESET;
      busy_q       <= 1'b0;
      level_q      <= '0;
      mask_q       <= '0;
      sec_q        <= lsgi_pkg::SEC_MAIN;
      sub_q        <= lsgi_pkg::TRI_0;
      row_q        <= '0;
      col_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        patch_log2_q <= cfg_wdata_i;
        busy_q       <= 1'b0;
      end else if (in_fire && cur_busy) begin
        busy_q       <= busy_d;
      end
      if (in_fire && cur_busy) begin
        level_q     <= cur_level;
        mask_q      <= cur_mask;
        sec_q       <= sec_d;
        sub_q       <= sub_d;
        row_q       <= row_d;
        col_q       <= col_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && cur_busy) begin
      corner_a_q <= corner_a_d;
      corner_b_q <= corner_b_d;
      corner_c_q <= corner_c_d;
      last_q     <= !busy_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign corner_a_o      = corner_a_q;
  assign corner_b_o      = corner_b_q;
  assign corner_c_o      = corner_c_q;
  assign last_in_range_o = last_q;

  assign in_main = busy_q && (sec_q == lsgi_pkg::SEC_MAIN);
  assign in_fan  = busy_q && (sec_q != lsgi_pkg::SEC_MAIN);

  `LSGI_ASSERT_NXT(a_last_ends_range, clk_i, rst_ni, in_fire && cur_busy && !busy_d, !busy_q)
  `LSGI_ASSERT_NXT(a_restart_yields, clk_i, rst_ni, in_fire && restart_i, out_valid_q)
  `LSGI_ASSERT_IMP(a_fan_is_stitched, clk_i, rst_ni, in_fan, (sec_q[4:1] & mask_q) != 4'd0)
  `LSGI_ASSERT_IMP(a_main_two_tris, clk_i, rst_ni, in_main, !sub_q[1])

endmodule
